### sv/whcf_pkg.sv
// ----------------------------------------------------------------------------
// whcf_pkg
// Shared constants and types for the wire hit cluster finder.
// ----------------------------------------------------------------------------
package whcf_pkg;

    // width of the saturating hit counter
    localparam int COUNT_BITS    = 8;

    // result queue geometry
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;

    // push request into the result queue: one or two words per hit
    typedef struct packed {
        logic first;
        logic second;
    } whcf_push_t;

endpackage

### sv/wire_hit_cluster_finder.sv
// ----------------------------------------------------------------------------
// wire_hit_cluster_finder
// Groups plane/cell ordered wire-chamber hits into clusters of adjacent cells.
// ----------------------------------------------------------------------------
// One hit is taken per clock while in_ready is high. The hit is compared
// against the open cluster and merged or used to start a new one in the same
// cycle; any finished clusters are written into a four-word result queue and
// show on the output the next cycle if it was empty. in_ready stays high while
// the queue holds two words or fewer, so with out_ready high the block
// sustains one hit per cycle while each hit yields one word at most; a hit
// that closes a cluster and ends the event yields two words, leaving in turn.
module wire_hit_cluster_finder #(
    parameter int CELL_BITS  = 8,
    parameter int PLANE_BITS = 6,
    parameter int TDC_BITS   = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    cfg_we,
    input  logic [PLANE_BITS-1:0]   cfg_data,
    // hit input
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [PLANE_BITS-1:0]   hit_plane,
    input  logic [CELL_BITS-1:0]    hit_cell,
    input  logic [TDC_BITS-1:0]     hit_width,
    input  logic [TDC_BITS-1:0]     hit_time,
    input  logic                    end_of_event,
    // cluster output
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PLANE_BITS-1:0]   cluster_plane,
    output logic [CELL_BITS-1:0]    min_cell,
    output logic [CELL_BITS-1:0]    max_cell,
    output logic [CELL_BITS:0]      center_twice,
    output logic [CELL_BITS:0]      cell_span,
    output logic [TDC_BITS+7:0]     total_width,
    output logic [TDC_BITS-1:0]     max_width,
    output logic [CELL_BITS-1:0]    max_width_cell,
    output logic [TDC_BITS-1:0]     earliest_time,
    output logic [CELL_BITS-1:0]    earliest_cell,
    output logic [whcf_pkg::COUNT_BITS-1:0] hit_count,
    output logic                    last
);
    import whcf_pkg::*;

    localparam int SUM_BITS = TDC_BITS + 8;

    typedef struct packed {
        logic [PLANE_BITS-1:0] plane;
        logic [CELL_BITS-1:0]  min_c;
        logic [CELL_BITS-1:0]  max_c;
        logic [CELL_BITS:0]    center;
        logic [CELL_BITS:0]    span;
        logic [SUM_BITS-1:0]   total;
        logic [TDC_BITS-1:0]   max_w;
        logic [CELL_BITS-1:0]  max_w_cell;
        logic [TDC_BITS-1:0]   early_t;
        logic [CELL_BITS-1:0]  early_cell;
        logic [COUNT_BITS-1:0] count;
        logic                  is_last;
    } rec_t;

    function automatic rec_t make_rec(
        input logic [PLANE_BITS-1:0] plane,
        input logic [CELL_BITS-1:0]  min_c,
        input logic [CELL_BITS-1:0]  max_c,
        input logic [SUM_BITS-1:0]   total,
        input logic [TDC_BITS-1:0]   max_w,
        input logic [CELL_BITS-1:0]  max_w_cell,
        input logic [TDC_BITS-1:0]   early_t,
        input logic [CELL_BITS-1:0]  early_cell,
        input logic [COUNT_BITS-1:0] count,
        input logic                  is_last
    );
        rec_t r;
        r.plane      = plane;
        r.min_c      = min_c;
        r.max_c      = max_c;
        r.center     = {1'b0, min_c} + {1'b0, max_c};
        r.span       = {1'b0, max_c} - {1'b0, min_c} + (CELL_BITS+1)'(1);
        r.total      = total;
        r.max_w      = max_w;
        r.max_w_cell = max_w_cell;
        r.early_t    = early_t;
        r.early_cell = early_cell;
        r.count      = count;
        r.is_last    = is_last;
        return r;
    endfunction

    // configuration and open cluster state
    logic [PLANE_BITS-1:0] max_plane_reg;
    logic                  open_valid_reg,  open_valid_next;
    logic [PLANE_BITS-1:0] open_plane_reg,  open_plane_next;
    logic [CELL_BITS-1:0]  prev_cell_reg,   prev_cell_next;
    logic [CELL_BITS-1:0]  min_cell_reg,    min_cell_next;
    logic [CELL_BITS-1:0]  max_cell_reg,    max_cell_next;
    logic [SUM_BITS-1:0]   total_reg,       total_next;
    logic [TDC_BITS-1:0]   max_w_reg,       max_w_next;
    logic [CELL_BITS-1:0]  max_w_cell_reg,  max_w_cell_next;
    logic [TDC_BITS-1:0]   early_t_reg,     early_t_next;
    logic [CELL_BITS-1:0]  early_cell_reg,  early_cell_next;
    logic [COUNT_BITS-1:0] count_reg,       count_next;

    logic                  in_fire;
    logic                  plane_ok;
    logic                  joins;
    logic                  closes;
    logic                  flushes;
    logic [SUM_BITS:0]     sum_wide;
    rec_t                  close_rec;
    rec_t                  flush_rec;
    rec_t                  head_rec;
    whcf_push_t            push;
    logic [FIFO_CNT_BITS-1:0] level;

    assign in_fire = in_valid && in_ready;
    assign in_ready = (level <= FIFO_CNT_BITS'(FIFO_DEPTH - 2));

    // hit classification against the open cluster
    always_comb
    begin
        plane_ok = (hit_plane <= max_plane_reg);
        joins    = plane_ok && open_valid_reg && (hit_plane == open_plane_reg) &&
                   ({1'b0, hit_cell} <= ({1'b0, prev_cell_reg} + (CELL_BITS+1)'(1)));
        closes   = plane_ok && !joins && open_valid_reg;
        flushes  = end_of_event && (open_valid_reg || plane_ok);
        sum_wide = {1'b0, total_reg} + (SUM_BITS+1)'(hit_width);
    end

    // next open cluster state
    always_comb
    begin
        open_valid_next = open_valid_reg;
        open_plane_next = open_plane_reg;
        prev_cell_next  = prev_cell_reg;
        min_cell_next   = min_cell_reg;
        max_cell_next   = max_cell_reg;
        total_next      = total_reg;
        max_w_next      = max_w_reg;
        max_w_cell_next = max_w_cell_reg;
        early_t_next    = early_t_reg;
        early_cell_next = early_cell_reg;
        count_next      = count_reg;
        if (joins)
        begin
            prev_cell_next = hit_cell;
            if (hit_cell < min_cell_reg)
            begin
                min_cell_next = hit_cell;
            end
            if (hit_cell > max_cell_reg)
            begin
                max_cell_next = hit_cell;
            end
            total_next = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];
            if (hit_width > max_w_reg)
            begin
                max_w_next      = hit_width;
                max_w_cell_next = hit_cell;
            end
            if (hit_time < early_t_reg)
            begin
                early_t_next    = hit_time;
                early_cell_next = hit_cell;
            end
            if (count_reg != '1)
            begin
                count_next = count_reg + COUNT_BITS'(1);
            end
        end
        else if (plane_ok)
        begin
            open_valid_next = 1'b1;
            open_plane_next = hit_plane;
            prev_cell_next  = hit_cell;
            min_cell_next   = hit_cell;
            max_cell_next   = hit_cell;
            total_next      = SUM_BITS'(hit_width);
            max_w_next      = hit_width;
            max_w_cell_next = hit_cell;
            early_t_next    = hit_time;
            early_cell_next = hit_cell;
            count_next      = COUNT_BITS'(1);
        end
        if (flushes)
        begin
            open_valid_next = 1'b0;
        end
    end

    // result words: the closed cluster and the flushed cluster
    always_comb
    begin
        close_rec = make_rec(open_plane_reg, min_cell_reg, max_cell_reg, total_reg,
                             max_w_reg, max_w_cell_reg, early_t_reg, early_cell_reg,
                             count_reg, !flushes);
        flush_rec = make_rec(open_plane_next, min_cell_next, max_cell_next, total_next,
                             max_w_next, max_w_cell_next, early_t_next, early_cell_next,
                             count_next, 1'b1);
        push.first  = in_fire && (closes || flushes);
        push.second = in_fire && closes && flushes;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_plane_reg  <= '1;
            open_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_plane_reg <= cfg_data;
            end
            if (in_fire)
            begin
                open_valid_reg <= open_valid_next;
            end
        end
    end

    // open cluster payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            open_plane_reg <= open_plane_next;
            prev_cell_reg  <= prev_cell_next;
            min_cell_reg   <= min_cell_next;
            max_cell_reg   <= max_cell_next;
            total_reg      <= total_next;
            max_w_reg      <= max_w_next;
            max_w_cell_reg <= max_w_cell_next;
            early_t_reg    <= early_t_next;
            early_cell_reg <= early_cell_next;
            count_reg      <= count_next;
        end
    end

    // result queue
    whcf_result_fifo #(
        .WIDTH($bits(rec_t))
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data0 (closes ? close_rec : flush_rec),
        .push_data1 (flush_rec),
        .pop        (out_valid && out_ready),
        .head_data  (head_rec),
        .level      (level)
    );

    // output word
    assign out_valid      = (level != '0);
    assign cluster_plane  = head_rec.plane;
    assign min_cell       = head_rec.min_c;
    assign max_cell       = head_rec.max_c;
    assign center_twice   = head_rec.center;
    assign cell_span      = head_rec.span;
    assign total_width    = head_rec.total;
    assign max_width      = head_rec.max_w;
    assign max_width_cell = head_rec.max_w_cell;
    assign earliest_time  = head_rec.early_t;
    assign earliest_cell  = head_rec.early_cell;
    assign hit_count      = head_rec.count;
    assign last           = head_rec.is_last;

`ifndef NO_ASSERTIONS
    // queue never holds more than its depth
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level <= FIFO_CNT_BITS'(FIFO_DEPTH))
        else $error("result queue overflow");

    // an end-of-event hit leaves no open cluster
    a_eoe_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && end_of_event |=> !open_valid_reg)
        else $error("open cluster survived end of event");

    // open cluster only changes when a hit is taken
    a_idle_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !in_fire |=> $stable(open_valid_reg))
        else $error("open cluster changed without a hit");

    // a hit that opens a cluster while one is open produces a word
    a_close_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && closes |-> push.first)
        else $error("closed cluster not queued");
`endif

endmodule

### sv/whcf_result_fifo.sv
// ----------------------------------------------------------------------------
// whcf_result_fifo
// Small result queue that takes up to two words per cycle and gives one.
// ----------------------------------------------------------------------------
module whcf_result_fifo #(
    parameter int WIDTH = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  whcf_pkg::whcf_push_t          push,
    input  logic [WIDTH-1:0]              push_data0,
    input  logic [WIDTH-1:0]              push_data1,
    input  logic                          pop,
    output logic [WIDTH-1:0]              head_data,
    output logic [whcf_pkg::FIFO_CNT_BITS-1:0] level
);
    import whcf_pkg::*;

    logic [WIDTH-1:0]         mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] wr_reg;
    logic [FIFO_PTR_BITS-1:0] wr_next;
    logic [FIFO_PTR_BITS-1:0] rd_reg;
    logic [FIFO_PTR_BITS-1:0] rd_next;
    logic [FIFO_CNT_BITS-1:0] level_reg;
    logic [FIFO_CNT_BITS-1:0] level_next;
    logic [FIFO_CNT_BITS-1:0] n_push;

    // pointer and level update
    always_comb
    begin
        n_push     = FIFO_CNT_BITS'(push.first) + FIFO_CNT_BITS'(push.second);
        wr_next    = wr_reg + n_push[FIFO_PTR_BITS-1:0];
        rd_next    = rd_reg + FIFO_PTR_BITS'(pop);
        level_next = level_reg + n_push - FIFO_CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            level_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            level_reg <= level_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push.first)
        begin
            mem_reg[wr_reg] <= push_data0;
        end
        if (push.second)
        begin
            mem_reg[wr_reg + FIFO_PTR_BITS'(1)] <= push_data1;
        end
    end

    assign head_data = mem_reg[rd_reg];
    assign level     = level_reg;

endmodule

### test/wire_hit_cluster_finder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wire_hit_cluster_finder_test
// Self-checking bench for the wire hit cluster finder. Directed hit lists
// cover the field extremes and each clustering corner: ties, backward cells,
// dropped planes, two clusters from one hit, and width/count saturation.
// Random events of adjacent hits with noise then run under several max_plane
// settings. A behavioral cluster builder predicts every emitted word, and a
// checker compares each output word field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module wire_hit_cluster_finder_test;

    import whcf_pkg::*;

    localparam int CELL_W         = 8;
    localparam int PLANE_W        = 6;
    localparam int TDC_W          = 16;
    localparam int SUM_W          = TDC_W + 8;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 6;
    localparam int WATCHDOG_LIMIT = 3000;

    typedef struct {
        logic [PLANE_W-1:0] plane;
        logic [CELL_W-1:0]  cell_idx;
        logic [TDC_W-1:0]   width;
        logic [TDC_W-1:0]   tdc_time;
        logic               eoe;
    } hit_t;

    typedef struct {
        logic [PLANE_W-1:0]    plane;
        logic [CELL_W-1:0]     min_c;
        logic [CELL_W-1:0]     max_c;
        logic [CELL_W:0]       center2;
        logic [CELL_W:0]       span;
        logic [SUM_W-1:0]      sum_w;
        logic [TDC_W-1:0]      max_w;
        logic [CELL_W-1:0]     max_w_cell;
        logic [TDC_W-1:0]      first_t;
        logic [CELL_W-1:0]     first_t_cell;
        logic [COUNT_BITS-1:0] hits;
        logic                  last;
    } cluster_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_we;
    logic [PLANE_W-1:0]      cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [PLANE_W-1:0]      hit_plane;
    logic [CELL_W-1:0]       hit_cell;
    logic [TDC_W-1:0]        hit_width;
    logic [TDC_W-1:0]        hit_time;
    logic                    end_of_event;
    logic                    out_valid;
    logic                    out_ready;
    logic [PLANE_W-1:0]      cluster_plane;
    logic [CELL_W-1:0]       min_cell;
    logic [CELL_W-1:0]       max_cell;
    logic [CELL_W:0]         center_twice;
    logic [CELL_W:0]         cell_span;
    logic [SUM_W-1:0]        total_width;
    logic [TDC_W-1:0]        max_width;
    logic [CELL_W-1:0]       max_width_cell;
    logic [TDC_W-1:0]        earliest_time;
    logic [CELL_W-1:0]       earliest_cell;
    logic [COUNT_BITS-1:0]   hit_count;
    logic                    last;

    // predicted cluster words still to come out of the block
    cluster_t expected_clusters[$];

    // predictor copy of the register and the open cluster
    logic [PLANE_W-1:0]    plane_limit;
    logic                  clu_open;
    logic [PLANE_W-1:0]    clu_plane;
    logic [CELL_W-1:0]     clu_prev_cell;
    logic [CELL_W-1:0]     clu_min;
    logic [CELL_W-1:0]     clu_max;
    logic [SUM_W-1:0]      clu_sum;
    logic [TDC_W-1:0]      clu_wmax;
    logic [CELL_W-1:0]     clu_wmax_cell;
    logic [TDC_W-1:0]      clu_tmin;
    logic [CELL_W-1:0]     clu_tmin_cell;
    logic [COUNT_BITS-1:0] clu_count;

    int  errors;
    int  quiet_cycles;
    bit  send_idle_on;
    bit  recv_idle_on;
    bit  hold_off_req;

    wire_hit_cluster_finder DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .hit_plane      (hit_plane),
        .hit_cell       (hit_cell),
        .hit_width      (hit_width),
        .hit_time       (hit_time),
        .end_of_event   (end_of_event),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .cluster_plane  (cluster_plane),
        .min_cell       (min_cell),
        .max_cell       (max_cell),
        .center_twice   (center_twice),
        .cell_span      (cell_span),
        .total_width    (total_width),
        .max_width      (max_width),
        .max_width_cell (max_width_cell),
        .earliest_time  (earliest_time),
        .earliest_cell  (earliest_cell),
        .hit_count      (hit_count),
        .last           (last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    // tdc value with extremes and repeats for ties
    function automatic logic [TDC_W-1:0] pick_tdc(logic [TDC_W-1:0] prev);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else if (r < 35)
            return prev;
        else
            return TDC_W'($urandom);
    endfunction

    function automatic hit_t mk_hit(int plane, int cell_idx, int width, int tdc_time, bit eoe);
        hit_t h;
        h.plane    = PLANE_W'(plane);
        h.cell_idx = CELL_W'(cell_idx);
        h.width    = TDC_W'(width);
        h.tdc_time = TDC_W'(tdc_time);
        h.eoe      = eoe;
        return h;
    endfunction

    // snapshot of the open cluster as an output word
    function automatic cluster_t open_cluster_word();
        cluster_t c;
        c.plane        = clu_plane;
        c.min_c        = clu_min;
        c.max_c        = clu_max;
        c.center2      = {1'b0, clu_min} + {1'b0, clu_max};
        c.span         = (CELL_W+1)'(1) + {1'b0, clu_max} - {1'b0, clu_min};
        c.sum_w        = clu_sum;
        c.max_w        = clu_wmax;
        c.max_w_cell   = clu_wmax_cell;
        c.first_t      = clu_tmin;
        c.first_t_cell = clu_tmin_cell;
        c.hits         = clu_count;
        c.last         = 1'b0;
        return c;
    endfunction

    // merge one accepted hit into the open cluster, queue the closed ones
    task automatic fold_hit(input hit_t h);
        cluster_t closed[$];
        if (h.plane <= plane_limit)
        begin
            if (clu_open && h.plane == clu_plane &&
                {1'b0, h.cell_idx} <= {1'b0, clu_prev_cell} + (CELL_W+1)'(1))
            begin
                clu_prev_cell = h.cell_idx;
                if (h.cell_idx < clu_min)
                    clu_min = h.cell_idx;
                if (h.cell_idx > clu_max)
                    clu_max = h.cell_idx;
                if ({SUM_W{1'b1}} - clu_sum < SUM_W'(h.width))
                    clu_sum = '1;
                else
                    clu_sum = clu_sum + SUM_W'(h.width);
                if (h.width > clu_wmax)
                begin
                    clu_wmax      = h.width;
                    clu_wmax_cell = h.cell_idx;
                end
                if (h.tdc_time < clu_tmin)
                begin
                    clu_tmin      = h.tdc_time;
                    clu_tmin_cell = h.cell_idx;
                end
                if (clu_count != '1)
                    clu_count = clu_count + COUNT_BITS'(1);
            end
            else
            begin
                if (clu_open)
                    closed.insert(closed.size(), open_cluster_word());
                clu_open      = 1'b1;
                clu_plane     = h.plane;
                clu_prev_cell = h.cell_idx;
                clu_min       = h.cell_idx;
                clu_max       = h.cell_idx;
                clu_sum       = SUM_W'(h.width);
                clu_wmax      = h.width;
                clu_wmax_cell = h.cell_idx;
                clu_tmin      = h.tdc_time;
                clu_tmin_cell = h.cell_idx;
                clu_count     = 1;
            end
        end
        // end of event flushes whatever is open
        if (h.eoe && clu_open)
        begin
            closed.insert(closed.size(), open_cluster_word());
            clu_open = 1'b0;
        end
        if (closed.size() > 0)
            closed[closed.size() - 1].last = 1'b1;
        foreach (closed[i])
            expected_clusters.insert(expected_clusters.size(), closed[i]);
    endtask

    // offer one hit word and wait for it to be taken
    task automatic send_hit(input hit_t h);
        int gap;
        gap = send_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     = 1'b1;
        hit_plane    = h.plane;
        hit_cell     = h.cell_idx;
        hit_width    = h.width;
        hit_time     = h.tdc_time;
        end_of_event = h.eoe;
        do
            @(posedge clk);
        while (!in_ready);
        fold_hit(h);
        @(negedge clk);
    endtask

    // stop offering and let every predicted word come out
    task automatic drain_clusters();
        in_valid = 1'b0;
        while (expected_clusters.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_max_plane(input int value);
        drain_clusters();
        cfg_we   = 1'b1;
        cfg_data = PLANE_W'(value);
        @(negedge clk);
        cfg_we      = 1'b0;
        plane_limit = PLANE_W'(value);
    endtask

    // extremes, ties, backward cells, plane change and two words from one hit
    task automatic test_directed_clusters();
        send_hit(mk_hit(0, 0, 0, 0, 1));
        send_hit(mk_hit(63, 255, 16'hffff, 16'hffff, 1));
        send_hit(mk_hit(63, 254, 5, 100, 0));
        send_hit(mk_hit(63, 255, 5, 100, 0));
        send_hit(mk_hit(63, 0, 7, 50, 0));
        send_hit(mk_hit(63, 3, 9, 9, 1));
        send_hit(mk_hit(1, 10, 300, 40, 0));
        send_hit(mk_hit(1, 11, 200, 30, 0));
        send_hit(mk_hit(2, 11, 1, 2, 0));
        send_hit(mk_hit(2, 12, 1, 2, 1));
        send_hit(mk_hit(4, 20, 8, 60, 0));
        send_hit(mk_hit(4, 20, 8, 60, 0));
        send_hit(mk_hit(4, 19, 12, 5, 0));
        send_hit(mk_hit(4, 25, 16'h8000, 16'h8000, 0));
        send_hit(mk_hit(4, 26, 16'h7fff, 16'h7fff, 1));
        drain_clusters();
    endtask

    // one long cluster drives total width and hit count into saturation
    task automatic test_width_saturation();
        for (int i = 0; i < 262; i++)
            send_hit(mk_hit(5, 7, 16'hffff, 1000 - i, i == 261));
        drain_clusters();
    endtask

    // hits above max_plane (10 here) are dropped but still flush on end of event
    task automatic test_dropped_planes();
        send_hit(mk_hit(11, 5, 1, 1, 1));
        send_hit(mk_hit(3, 5, 10, 10, 0));
        send_hit(mk_hit(63, 6, 99, 0, 0));
        send_hit(mk_hit(3, 6, 20, 5, 0));
        send_hit(mk_hit(40, 9, 1, 1, 1));
        send_hit(mk_hit(10, 0, 3, 3, 0));
        send_hit(mk_hit(11, 1, 4, 4, 0));
        send_hit(mk_hit(10, 1, 4, 2, 0));
        send_hit(mk_hit(32, 200, 0, 0, 1));
        drain_clusters();
    endtask

    // output held off for a long stretch while hits keep coming
    task automatic test_output_hold_off();
        send_idle_on = 1'b0;
        hold_off_req = 1'b1;
        while (hold_off_req)
            @(negedge clk);
        for (int i = 0; i < 30; i++)
            send_hit(mk_hit(2, i * 2, i, 100 - i, (i % 3) == 2 || i == 29));
        drain_clusters();
        send_idle_on = 1'b1;
    endtask

    // random events of mostly adjacent hits, with some noise words
    task automatic test_random_hits(input int n_hits);
        int                 sent;
        int                 n_event;
        int                 r;
        logic [PLANE_W-1:0] plane;
        logic [CELL_W-1:0]  cell_idx;
        hit_t               h;
        sent = 0;
        h = mk_hit(0, 0, 0, 0, 0);
        while (sent < n_hits)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                h.plane    = PLANE_W'($urandom);
                h.cell_idx = CELL_W'($urandom);
                h.width    = TDC_W'($urandom);
                h.tdc_time = TDC_W'($urandom);
                h.eoe      = ($urandom_range(0, 3) == 0);
                send_hit(h);
                if (h.plane <= plane_limit)
                    sent++;
            end
            else
            begin
                plane    = PLANE_W'($urandom_range(0, plane_limit));
                cell_idx = CELL_W'($urandom);
                n_event  = $urandom_range(1, 12);
                for (int i = 0; i < n_event; i++)
                begin
                    r = $urandom_range(0, 99);
                    h.plane = plane;
                    if (i > 0)
                    begin
                        if (r < 45)
                            cell_idx = cell_idx + CELL_W'(1);
                        else if (r >= 60 && r < 72)
                            cell_idx = cell_idx + CELL_W'($urandom_range(2, 12));
                        else if (r >= 72 && r < 82)
                        begin
                            if (plane < plane_limit)
                                plane = plane + PLANE_W'(1);
                            else
                                cell_idx = cell_idx + CELL_W'($urandom_range(2, 12));
                            h.plane = plane;
                        end
                        else if (r >= 82 && r < 92)
                            cell_idx = cell_idx - CELL_W'($urandom_range(1, 4));
                        else if (r >= 92 && plane_limit != '1)
                            h.plane = PLANE_W'($urandom_range(plane_limit + 1, 63));
                    end
                    h.cell_idx = cell_idx;
                    h.width    = pick_tdc(h.width);
                    h.tdc_time = pick_tdc(h.tdc_time);
                    if (i == n_event - 1)
                        h.eoe = ($urandom_range(0, 9) != 0);
                    else
                        h.eoe = ($urandom_range(0, 29) == 0);
                    send_hit(h);
                    if (h.plane <= plane_limit)
                        sent++;
                end
            end
        end
        drain_clusters();
    endtask

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // compare each output word with the oldest prediction
    always @(posedge clk)
    begin
        cluster_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_clusters.size() == 0)
            begin
                $display("%0t: unexpected cluster word, expected none, actual plane %0d cells %0d..%0d",
                         $time, cluster_plane, min_cell, max_cell);
                errors++;
            end
            else
            begin
                want = expected_clusters.pop_front();
                check_field("cluster_plane", want.plane, cluster_plane);
                check_field("min_cell", want.min_c, min_cell);
                check_field("max_cell", want.max_c, max_cell);
                check_field("center_twice", want.center2, center_twice);
                check_field("cell_span", want.span, cell_span);
                check_field("total_width", want.sum_w, total_width);
                check_field("max_width", want.max_w, max_width);
                check_field("max_width_cell", want.max_w_cell, max_width_cell);
                check_field("earliest_time", want.first_t, earliest_time);
                check_field("earliest_cell", want.first_t_cell, earliest_cell);
                check_field("hit_count", want.hits, hit_count);
                check_field("last", want.last, last);
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left = 0;
        out_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                stall_left   = HOLD_CYCLES;
            end
            else if (stall_left == 0 && recv_idle_on)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                out_ready  = 1'b0;
                stall_left = stall_left - 1;
            end
            else
                out_ready = 1'b1;
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // test sequence
    initial
    begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        hit_plane    = '0;
        hit_cell     = '0;
        hit_width    = '0;
        hit_time     = '0;
        end_of_event = 1'b0;
        errors       = 0;
        quiet_cycles = 0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        hold_off_req = 1'b0;
        plane_limit  = '1;
        clu_open     = 1'b0;
        clu_plane    = '0;
        clu_prev_cell = '0;
        clu_min      = '0;
        clu_max      = '0;
        clu_sum      = '0;
        clu_wmax     = '0;
        clu_wmax_cell = '0;
        clu_tmin     = '0;
        clu_tmin_cell = '0;
        clu_count    = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed_clusters();
        test_width_saturation();
        write_max_plane(10);
        test_dropped_planes();
        test_output_hold_off();

        write_max_plane(0);
        test_random_hits(30);

        // steady stretch with no idling, then idling again
        write_max_plane($urandom_range(1, 62));
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        test_random_hits(20);
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        test_random_hits(20);

        write_max_plane(63);
        test_random_hits(30);

        write_max_plane($urandom_range(1, 62));
        test_random_hits(20);

        drain_clusters();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### files.f
sv/whcf_pkg.sv
sv/whcf_result_fifo.sv
sv/wire_hit_cluster_finder.sv
test/wire_hit_cluster_finder_test.sv
